FILE: rtl/msfd_pkg.sv
// shared types and constants for the magic sync frame deframer
package msfd_pkg;

  localparam int HDR_LEN    = 28;
  localparam int MAGIC_LEN  = 4;
  localparam int SCAN_LEN   = HDR_LEN - MAGIC_LEN;
  localparam int IDX_W      = $clog2(HDR_LEN);
  localparam int PLEN_W     = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [7:0]  MAGIC_T    = 8'h54;
  localparam logic [7:0]  MAGIC_L    = 8'h4C;
  localparam logic [7:0]  MAGIC_B    = 8'h42;
  localparam logic [7:0]  MAGIC_C    = 8'h43;
  localparam logic [23:0] MAGIC_HEAD = {MAGIC_T, MAGIC_L, MAGIC_B};

  localparam logic [PLEN_W-1:0] MAX_LEN_RST = PLEN_W'(64 * 1024 * 1024);
  localparam logic [7:0]        DIR_RST     = 8'd1;
  localparam logic [15:0]       TOPIC_RST   = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LEN   = 2'd0,
    CFG_FILTER_EN = 2'd1,
    CFG_ACC_DIR   = 2'd2,
    CFG_ACC_TOPIC = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_HEADER,
    ST_PAYLOAD,
    ST_SCAN_HUNT,
    ST_SCAN_HEADER
  } state_t;

  typedef enum logic {
    REQ_BYTE  = 1'b0,
    REQ_RESET = 1'b1
  } req_t;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } kind_t;

  typedef struct packed {
    logic sel_replay;
    logic win_shift;
    logic win_clear;
    logic magic_load;
    logic store_write;
    logic count_clear;
    logic out_load_hdr;
    logic out_load_pay;
    logic rem_load;
    logic rem_dec;
    logic pass_load;
    logic pass_clear;
    logic replay_clear;
    logic replay_inc;
    logic clear_all;
  } cmd_t;

  typedef struct packed {
    logic magic_hit;
    logic hdr_done;
    logic len_bad;
    logic len_zero;
    logic pass_calc;
    logic frame_pass;
    logic rem_last;
    logic rem_nz;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/msfd_if.sv
// stream channel interfaces for received bytes and deframed results
interface msfd_rx_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, req_type, rx_byte, input ready);
  modport sink (input valid, req_type, rx_byte, output ready);
endinterface

interface msfd_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  version;
  logic [7:0]  direction;
  logic [15:0] topic_num;
  logic [63:0] sequence_res;
  logic [63:0] stamp_raw;
  logic [26:0] body_len;
  logic [7:0]  data_byte;
  logic        last;

  modport source (output valid, kind, version, direction, topic_num, sequence_res,
                  stamp_raw, body_len, data_byte, last, input ready);
  modport sink (input valid, kind, version, direction, topic_num, sequence_res,
                stamp_raw, body_len, data_byte, last, output ready);
endinterface

FILE: rtl/magic_sync_frame_deframer.sv
// top level of the magic sync frame deframer
// Takes one received byte (or a link-reset request) per beat and hunts for the
// magic "TLBC", gathers the 28-byte big-endian header, then emits one header
// result for a frame that passes the direction/topic filter followed by one
// result per payload byte, the last result marked. In the hunt, header and
// payload phases a byte is taken every cycle while the result register has
// room. A header whose length exceeds the limit starts a rescan of its 24 held
// bytes through the header store read port, one byte a cycle, with the input
// stalled. The user writes configuration through cfg_we/cfg_index/cfg_data
// only while the block is idle, which the block does not enforce; link reset keeps it.
module magic_sync_frame_deframer #(
  parameter int LEN_COUNT_BITS = 27
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [msfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msfd_pkg::CFG_DATA_W-1:0] cfg_data,
  msfd_rx_if.sink                         rx_ch,
  msfd_res_if.source                      res_ch
);
  import msfd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_ch.valid),
    .rx_ready (rx_ch.ready),
    .req_type (rx_ch.req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  msfd_dp #(
    .LEN_COUNT_BITS (LEN_COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_ch.rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .res_valid    (res_ch.valid),
    .res_ready    (res_ch.ready),
    .kind         (res_ch.kind),
    .version      (res_ch.version),
    .direction    (res_ch.direction),
    .topic_num    (res_ch.topic_num),
    .sequence_res (res_ch.sequence_res),
    .stamp_raw    (res_ch.stamp_raw),
    .body_len     (res_ch.body_len),
    .data_byte    (res_ch.data_byte),
    .last         (res_ch.last)
  );
endmodule

FILE: rtl/msfd_dp.sv
// deframer datapath: match window, header store, counters, config and result register
module msfd_dp #(
  parameter int LEN_COUNT_BITS = 27
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [msfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                   rx_byte,
  input  msfd_pkg::cmd_t               cmd,
  output msfd_pkg::sts_t               sts,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic                         kind,
  output logic [7:0]                   version,
  output logic [7:0]                   direction,
  output logic [15:0]                  topic_num,
  output logic [63:0]                  sequence_res,
  output logic [63:0]                  stamp_raw,
  output logic [msfd_pkg::PLEN_W-1:0]  body_len,
  output logic [7:0]                   data_byte,
  output logic                         last
);
  import msfd_pkg::*;

  localparam logic [32:0] CAP = (33'd1 << LEN_COUNT_BITS) - 33'd1;
  localparam logic [LEN_COUNT_BITS-1:0] REM_ONE = LEN_COUNT_BITS'(1);

  logic [PLEN_W-1:0] max_len;
  logic              filter_en;
  logic [7:0]        acc_dir;
  logic [15:0]       acc_topic;

  logic [23:0]               window;
  logic [7:0]                store [HDR_LEN];
  logic [IDX_W-1:0]          count;
  logic [IDX_W-1:0]          replay;
  logic [LEN_COUNT_BITS-1:0] rem;
  logic                      frame_pass;

  logic [IDX_W-1:0] scan_addr;
  logic [7:0]       cur_byte;
  logic [31:0]      len;

  assign scan_addr = replay + IDX_W'(MAGIC_LEN);
  assign cur_byte  = cmd.sel_replay ? store[scan_addr] : rx_byte;
  assign len       = {store[24], store[25], store[26], cur_byte};

  always_comb begin
    sts.magic_hit  = (window == MAGIC_HEAD) && (cur_byte == MAGIC_C);
    sts.hdr_done   = (count == IDX_W'(HDR_LEN - 1));
    sts.len_bad    = ({1'b0, len} > {6'd0, max_len}) || ({1'b0, len} > CAP);
    sts.len_zero   = (len == 32'd0);
    sts.pass_calc  = !filter_en || ((store[5] == acc_dir) &&
                                    ({store[6], store[7]} == acc_topic));
    sts.frame_pass = frame_pass;
    sts.rem_last   = (rem == REM_ONE);
    sts.rem_nz     = |rem;
    sts.scan_done  = (replay == IDX_W'(SCAN_LEN - 1));
    sts.out_free   = !res_valid || res_ready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len   <= MAX_LEN_RST;
      filter_en <= 1'b1;
      acc_dir   <= DIR_RST;
      acc_topic <= TOPIC_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_LEN:   max_len   <= cfg_data[PLEN_W-1:0];
        CFG_FILTER_EN: filter_en <= cfg_data[0];
        CFG_ACC_DIR:   acc_dir   <= cfg_data[7:0];
        CFG_ACC_TOPIC: acc_topic <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // framing state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      window     <= '0;
      count      <= '0;
      replay     <= '0;
      rem        <= '0;
      frame_pass <= 1'b0;
    end else begin
      if (cmd.win_clear) begin
        window <= '0;
      end else if (cmd.win_shift) begin
        window <= {window[15:0], cur_byte};
      end
      if (cmd.count_clear) begin
        count <= '0;
      end else if (cmd.magic_load) begin
        count <= IDX_W'(MAGIC_LEN);
      end else if (cmd.store_write) begin
        count <= count + IDX_W'(1);
      end
      if (cmd.replay_clear) begin
        replay <= '0;
      end else if (cmd.replay_inc) begin
        replay <= replay + IDX_W'(1);
      end
      if (cmd.rem_load) begin
        rem <= len[LEN_COUNT_BITS-1:0];
      end else if (cmd.rem_dec) begin
        rem <= rem - REM_ONE;
      end
      if (cmd.pass_clear) begin
        frame_pass <= 1'b0;
      end else if (cmd.pass_load) begin
        frame_pass <= sts.pass_calc;
      end
    end
  end

  // header store
  always_ff @(posedge clk) begin
    if (cmd.magic_load) begin
      store[0] <= MAGIC_T;
      store[1] <= MAGIC_L;
      store[2] <= MAGIC_B;
      store[3] <= MAGIC_C;
    end else if (cmd.store_write) begin
      store[count] <= cur_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load_hdr || cmd.out_load_pay) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_hdr) begin
      kind         <= KIND_HEADER;
      version      <= store[4];
      direction    <= store[5];
      topic_num    <= {store[6], store[7]};
      sequence_res <= {store[8], store[9], store[10], store[11],
                       store[12], store[13], store[14], store[15]};
      stamp_raw    <= {store[16], store[17], store[18], store[19],
                       store[20], store[21], store[22], store[23]};
      body_len     <= len[PLEN_W-1:0];
      data_byte    <= '0;
      last         <= sts.len_zero;
    end else if (cmd.out_load_pay) begin
      kind         <= KIND_PAYLOAD;
      version      <= '0;
      direction    <= '0;
      topic_num    <= '0;
      sequence_res <= '0;
      stamp_raw    <= '0;
      body_len     <= '0;
      data_byte    <= cur_byte;
      last         <= sts.rem_last;
    end
  end

  a_load_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load_hdr || cmd.out_load_pay) |-> sts.out_free)
    else $error("result loaded over an untaken beat");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.store_write |-> (count >= IDX_W'(MAGIC_LEN)))
    else $error("header byte written before magic");

  a_rem_counts_down: assert property (@(posedge clk) disable iff (rst)
    (cmd.rem_dec && !cmd.clear_all) |=> (rem == $past(rem) - REM_ONE))
    else $error("payload count did not step");
endmodule

FILE: rtl/msfd_ctrl.sv
// deframer controller: hunt, header, payload and rescan sequencing
module msfd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           rx_valid,
  output logic           rx_ready,
  input  logic           req_type,
  input  msfd_pkg::sts_t sts,
  output msfd_pkg::cmd_t cmd
);
  import msfd_pkg::*;

  state_t state, state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    rx_ready   = sts.out_free &&
                 (state == ST_HUNT || state == ST_HEADER || state == ST_PAYLOAD);
    accept     = rx_valid && rx_ready;

    unique case (state)
      ST_HUNT, ST_HEADER, ST_PAYLOAD: begin
        if (accept) begin
          if (req_t'(req_type) == REQ_RESET) begin
            cmd.clear_all = 1'b1;
            state_next    = ST_HUNT;
          end else if (state == ST_HUNT) begin
            if (sts.magic_hit) begin
              cmd.magic_load = 1'b1;
              cmd.win_clear  = 1'b1;
              state_next     = ST_HEADER;
            end else begin
              cmd.win_shift = 1'b1;
            end
          end else if (state == ST_HEADER) begin
            cmd.store_write = 1'b1;
            if (sts.hdr_done) begin
              cmd.count_clear = 1'b1;
              if (sts.len_bad) begin
                cmd.win_clear    = 1'b1;
                cmd.replay_clear = 1'b1;
                state_next       = ST_SCAN_HUNT;
              end else begin
                cmd.out_load_hdr = sts.pass_calc;
                if (sts.len_zero) begin
                  cmd.win_clear  = 1'b1;
                  cmd.pass_clear = 1'b1;
                  state_next     = ST_HUNT;
                end else begin
                  cmd.pass_load = 1'b1;
                  cmd.rem_load  = 1'b1;
                  state_next    = ST_PAYLOAD;
                end
              end
            end
          end else begin
            cmd.rem_dec      = 1'b1;
            cmd.out_load_pay = sts.frame_pass;
            if (sts.rem_last) begin
              cmd.win_clear   = 1'b1;
              cmd.count_clear = 1'b1;
              cmd.pass_clear  = 1'b1;
              state_next      = ST_HUNT;
            end
          end
        end
      end
      ST_SCAN_HUNT: begin
        cmd.sel_replay = 1'b1;
        if (sts.magic_hit) begin
          cmd.magic_load = 1'b1;
          cmd.win_clear  = 1'b1;
        end else begin
          cmd.win_shift = 1'b1;
        end
        if (sts.scan_done) begin
          cmd.replay_clear = 1'b1;
          state_next       = sts.magic_hit ? ST_HEADER : ST_HUNT;
        end else begin
          cmd.replay_inc = 1'b1;
          state_next     = sts.magic_hit ? ST_SCAN_HEADER : ST_SCAN_HUNT;
        end
      end
      ST_SCAN_HEADER: begin
        cmd.sel_replay  = 1'b1;
        cmd.store_write = 1'b1;
        if (sts.scan_done) begin
          cmd.replay_clear = 1'b1;
          state_next       = ST_HEADER;
        end else begin
          cmd.replay_inc = 1'b1;
        end
      end
      default: state_next = ST_HUNT;
    endcase
  end

  a_scan_never_fills: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN_HEADER) |-> !sts.hdr_done)
    else $error("rescan completed a header");

  a_payload_count_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAYLOAD) |-> sts.rem_nz)
    else $error("payload phase with nothing left");

  a_reject_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && state == ST_HEADER && req_t'(req_type) == REQ_BYTE &&
     sts.hdr_done && sts.len_bad) |=> (state == ST_SCAN_HUNT))
    else $error("rejected header did not start rescan");
endmodule

FILE: tb/tb.sv
// self-checking testbench for the magic sync frame deframer
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msfd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int SEG_BEATS     = 55;

  typedef enum logic [1:0] {DF_HUNT, DF_HEADER, DF_PAYLOAD} df_phase_t;

  typedef struct {
    req_t       rq;
    logic [7:0] data;
  } rx_beat_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  version;
    logic [7:0]  direction;
    logic [15:0] topic_num;
    logic [63:0] sequence_res;
    logic [63:0] stamp_raw;
    logic [26:0] body_len;
    logic [7:0]  data_byte;
    logic        last;
  } deframed_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  msfd_rx_if  rx_ch();
  msfd_res_if res_ch();

  magic_sync_frame_deframer uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rx_ch(rx_ch),
    .res_ch(res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rx_beat_t  beat_fifo[$];
  deframed_t expected_frames[$];
  int        mismatches = 0;
  int        seg_beats;
  int        tx_gap_pct = 0;
  int        sink_stall_pct = 0;
  int unsigned cycle_count = 0;

  // deframer state mirror
  df_phase_t   df_phase = DF_HUNT;
  logic [23:0] df_window = '0;
  logic [7:0]  df_hdr [HDR_LEN];
  int          df_hdr_cnt = 0;
  logic [26:0] df_remaining = '0;
  bit          df_pass = 1'b0;

  logic [26:0] lim_len = MAX_LEN_RST;
  logic        flt_on = 1'b1;
  logic [7:0]  want_dir = DIR_RST;
  logic [15:0] want_topic = TOPIC_RST;

  function automatic bit take_hdr_byte(input logic [7:0] b);
    if (df_phase == DF_HEADER) begin
      df_hdr[df_hdr_cnt] = b;
      df_hdr_cnt++;
      return df_hdr_cnt >= HDR_LEN;
    end
    if (df_window == MAGIC_HEAD && b == MAGIC_C) begin
      df_hdr[0] = MAGIC_T;
      df_hdr[1] = MAGIC_L;
      df_hdr[2] = MAGIC_B;
      df_hdr[3] = MAGIC_C;
      df_hdr_cnt = MAGIC_LEN;
      df_phase = DF_HEADER;
      df_window = '0;
    end else begin
      df_window = {df_window[15:0], b};
    end
    return 1'b0;
  endfunction

  function automatic void predict_beat(input req_t rq, input logic [7:0] b);
    deframed_t r;
    logic [31:0] len;
    logic [7:0] held [SCAN_LEN];
    int i;
    r.kind = KIND_HEADER;
    r.version = '0;
    r.direction = '0;
    r.topic_num = '0;
    r.sequence_res = '0;
    r.stamp_raw = '0;
    r.body_len = '0;
    r.data_byte = '0;
    r.last = 1'b0;
    if (rq == REQ_RESET) begin
      df_phase = DF_HUNT;
      df_window = '0;
      df_hdr_cnt = 0;
      df_remaining = '0;
      df_pass = 1'b0;
      return;
    end
    if (df_phase == DF_PAYLOAD) begin
      if (df_remaining != 0) df_remaining--;
      r.kind = KIND_PAYLOAD;
      r.data_byte = b;
      r.last = (df_remaining == 0);
      if (df_pass) expected_frames.insert(expected_frames.size(), r);
      if (r.last) begin
        df_phase = DF_HUNT;
        df_window = '0;
        df_hdr_cnt = 0;
        df_pass = 1'b0;
      end
      return;
    end
    if (!take_hdr_byte(b)) return;
    len = {df_hdr[24], df_hdr[25], df_hdr[26], df_hdr[27]};
    df_hdr_cnt = 0;
    if (len > {5'd0, lim_len}) begin
      // drop the magic and rescan what followed it
      for (i = 0; i < SCAN_LEN; i++) held[i] = df_hdr[MAGIC_LEN + i];
      df_phase = DF_HUNT;
      df_window = '0;
      for (i = 0; i < SCAN_LEN; i++) void'(take_hdr_byte(held[i]));
      return;
    end
    df_pass = !flt_on || (df_hdr[5] == want_dir && {df_hdr[6], df_hdr[7]} == want_topic);
    r.version = df_hdr[4];
    r.direction = df_hdr[5];
    r.topic_num = {df_hdr[6], df_hdr[7]};
    for (i = 0; i < 8; i++) begin
      r.sequence_res = {r.sequence_res[55:0], df_hdr[8 + i]};
      r.stamp_raw = {r.stamp_raw[55:0], df_hdr[16 + i]};
    end
    r.body_len = len[26:0];
    r.last = (len == 0);
    if (df_pass) expected_frames.insert(expected_frames.size(), r);
    if (len == 0) begin
      df_phase = DF_HUNT;
      df_window = '0;
      df_pass = 1'b0;
    end else begin
      df_remaining = len[26:0];
      df_phase = DF_PAYLOAD;
    end
  endfunction

  function automatic void queue_beat(input req_t rq, input logic [7:0] b);
    beat_fifo.insert(beat_fifo.size(), '{rq: rq, data: b});
    seg_beats++;
  endfunction

  function automatic void queue_frame(input logic [7:0] ver, input logic [7:0] dir,
                                      input logic [15:0] topic, input logic [63:0] seq,
                                      input logic [63:0] stamp, input logic [31:0] len,
                                      input int n_pay, input int magic_at);
    logic [7:0] h [HDR_LEN];
    int i;
    h[0] = MAGIC_T;
    h[1] = MAGIC_L;
    h[2] = MAGIC_B;
    h[3] = MAGIC_C;
    h[4] = ver;
    h[5] = dir;
    h[6] = topic[15:8];
    h[7] = topic[7:0];
    for (i = 0; i < 8; i++) begin
      h[8 + i] = seq[63 - 8*i -: 8];
      h[16 + i] = stamp[63 - 8*i -: 8];
    end
    for (i = 0; i < 4; i++) h[24 + i] = len[31 - 8*i -: 8];
    if (magic_at >= 0) begin
      h[magic_at] = MAGIC_T;
      h[magic_at + 1] = MAGIC_L;
      h[magic_at + 2] = MAGIC_B;
      h[magic_at + 3] = MAGIC_C;
    end
    for (i = 0; i < HDR_LEN; i++) queue_beat(REQ_BYTE, h[i]);
    for (i = 0; i < n_pay; i++) queue_beat(REQ_BYTE, 8'($urandom));
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic apply_config(input logic [26:0] max_len, input logic filt,
                              input logic [7:0] dir, input logic [15:0] topic);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_LEN;
    cfg_data <= max_len;
    @(posedge clk);
    cfg_index <= CFG_FILTER_EN;
    cfg_data <= {26'd0, filt};
    @(posedge clk);
    cfg_index <= CFG_ACC_DIR;
    cfg_data <= {19'd0, dir};
    @(posedge clk);
    cfg_index <= CFG_ACC_TOPIC;
    cfg_data <= {11'd0, topic};
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_len = max_len;
    flt_on = filt;
    want_dir = dir;
    want_topic = topic;
  endtask

  // sender holds off until every result is out, then lets a rescan finish
  task automatic wait_drained();
    while (beat_fifo.size() != 0 || rx_ch.valid || expected_frames.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input beat driver
  always @(posedge clk) begin
    rx_beat_t nxt;
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) predict_beat(req_t'(rx_ch.req_type), rx_ch.rx_byte);
      if (!rx_ch.valid || rx_ch.ready) begin
        if (beat_fifo.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
          nxt = beat_fifo.pop_front();
          rx_ch.valid <= 1'b1;
          rx_ch.req_type <= nxt.rq;
          rx_ch.rx_byte <= nxt.data;
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);

  // result monitor
  always @(posedge clk) begin
    deframed_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected result: kind %0d data_byte %0h", res_ch.kind, res_ch.data_byte);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        check_field("kind", want.kind, res_ch.kind);
        check_field("version", want.version, res_ch.version);
        check_field("direction", want.direction, res_ch.direction);
        check_field("topic_num", want.topic_num, res_ch.topic_num);
        check_field("sequence_res", want.sequence_res, res_ch.sequence_res);
        check_field("stamp_raw", want.stamp_raw, res_ch.stamp_raw);
        check_field("body_len", want.body_len, res_ch.body_len);
        check_field("data_byte", want.data_byte, res_ch.data_byte);
        check_field("last", want.last, res_ch.last);
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("magic_sync_frame_deframer verification failed");
    $finish;
  end

  initial begin
    int seg;
    int pick;
    int len_cap;
    int k;
    logic [31:0] len;
    logic [7:0] dir;
    logic [15:0] topic;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_LEN;
    cfg_data = '0;
    rx_ch.valid = 1'b0;
    rx_ch.req_type = REQ_BYTE;
    rx_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    tx_gap_pct = 31;
    sink_stall_pct = 86;

    // partial magic ahead of a frame, extreme byte values
    queue_beat(REQ_BYTE, 8'h00);
    queue_beat(REQ_BYTE, 8'hFF);
    queue_beat(REQ_BYTE, MAGIC_T);
    queue_beat(REQ_BYTE, MAGIC_T);
    queue_beat(REQ_BYTE, MAGIC_L);
    queue_beat(REQ_BYTE, MAGIC_B);
    queue_frame(8'h00, DIR_RST, TOPIC_RST, '1, '0, 32'd2, 2, -1);
    // empty payload
    queue_frame(8'hFF, DIR_RST, TOPIC_RST, '0, '1, 32'd0, 0, -1);
    // filtered out on topic, then on direction
    queue_frame(8'h11, DIR_RST, TOPIC_RST + 16'd1, {$urandom, $urandom}, {$urandom, $urandom},
                32'd3, 3, -1);
    queue_frame(8'h22, 8'h00, TOPIC_RST, {$urandom, $urandom}, {$urandom, $urandom},
                32'd1, 1, -1);
    // oversized length hiding a magic in the stamp; the rescan starts a new header
    queue_frame(8'h33, DIR_RST, TOPIC_RST, {$urandom, $urandom}, '0, 32'h0701_0064, 0, 20);
    for (k = 0; k < 16; k++) queue_beat(REQ_BYTE, 8'($urandom));
    queue_beat(REQ_BYTE, 8'h00);
    queue_beat(REQ_BYTE, 8'h00);
    queue_beat(REQ_BYTE, 8'h00);
    queue_beat(REQ_BYTE, 8'h01);
    queue_beat(REQ_BYTE, 8'hA5);
    // one past the limit
    queue_frame(8'h44, DIR_RST, TOPIC_RST, '0, '0, {5'd0, MAX_LEN_RST} + 32'd1, 0, -1);
    // link reset mid header
    queue_beat(REQ_BYTE, MAGIC_T);
    queue_beat(REQ_BYTE, MAGIC_L);
    queue_beat(REQ_BYTE, MAGIC_B);
    queue_beat(REQ_BYTE, MAGIC_C);
    for (k = 0; k < 6; k++) queue_beat(REQ_BYTE, 8'($urandom));
    queue_beat(REQ_RESET, 8'($urandom));
    queue_frame(8'h55, DIR_RST, TOPIC_RST, {$urandom, $urandom}, {$urandom, $urandom},
                32'd4, 4, -1);
    // link reset clears a partial magic in the window
    queue_beat(REQ_BYTE, MAGIC_T);
    queue_beat(REQ_BYTE, MAGIC_L);
    queue_beat(REQ_BYTE, MAGIC_B);
    queue_beat(REQ_RESET, 8'hFF);
    queue_beat(REQ_BYTE, MAGIC_C);
    queue_frame(8'h66, DIR_RST, TOPIC_RST, {$urandom, $urandom}, {$urandom, $urandom},
                32'd1, 1, -1);
    wait_drained();

    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: apply_config(MAX_LEN_RST, 1'b1, DIR_RST, TOPIC_RST);
        1: apply_config(27'd0, 1'b1, 8'h00, 16'h0000);
        2: apply_config(27'd5, 1'b0, 8'hFF, 16'hFFFF);
        3: apply_config(27'd12, 1'b1, 8'hFF, 16'hFFFF);
        4: apply_config(27'($urandom_range(1, 16)), 1'b1, 8'($urandom), 16'($urandom));
        default: apply_config(27'd64, 1'b0, 8'($urandom), 16'($urandom));
      endcase
      case (seg / 2)
        0: begin
          tx_gap_pct = 31;
          sink_stall_pct = 86;
        end
        1: begin
          tx_gap_pct = 86;
          sink_stall_pct = 31;
        end
        default: begin
          tx_gap_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      seg_beats = 0;
      while (seg_beats < SEG_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          len_cap = (lim_len < 10) ? int'(lim_len) : 10;
          len = $urandom_range(0, len_cap);
          if (lim_len <= 64 && $urandom_range(0, 5) == 0) len = {5'd0, lim_len};
          dir = ($urandom_range(0, 3) != 0) ? want_dir : 8'($urandom);
          topic = ($urandom_range(0, 3) != 0) ? want_topic : 16'($urandom);
          if (len > 1 && $urandom_range(0, 9) == 0) begin
            queue_frame(8'($urandom), dir, topic, {$urandom, $urandom}, {$urandom, $urandom},
                        len, $urandom_range(0, len - 1), -1);
            queue_beat(REQ_RESET, 8'($urandom));
          end else begin
            queue_frame(8'($urandom), dir, topic, {$urandom, $urandom}, {$urandom, $urandom},
                        len, len, -1);
          end
        end else if (pick < 70) begin
          len = $urandom_range(0, 1) ? {5'd0, lim_len} + 32'($urandom_range(1, 3))
                                     : ($urandom | 32'h8000_0000);
          queue_frame(8'($urandom), want_dir, want_topic, {$urandom, $urandom},
                      {$urandom, $urandom}, len, 0,
                      ($urandom_range(0, 2) == 0) ? $urandom_range(4, 24) : -1);
        end else if (pick < 90) begin
          k = $urandom_range(0, 3);
          if (k > 0) queue_beat(REQ_BYTE, MAGIC_T);
          if (k > 1) queue_beat(REQ_BYTE, MAGIC_L);
          if (k > 2) queue_beat(REQ_BYTE, MAGIC_B);
          if ($urandom_range(0, 3) == 0) begin
            // truncated header cut off by a link reset
            if (k < 3) begin
              queue_beat(REQ_BYTE, MAGIC_T);
              queue_beat(REQ_BYTE, MAGIC_L);
              queue_beat(REQ_BYTE, MAGIC_B);
            end
            queue_beat(REQ_BYTE, MAGIC_C);
            repeat ($urandom_range(0, 20)) queue_beat(REQ_BYTE, 8'($urandom));
            queue_beat(REQ_RESET, 8'($urandom));
          end else begin
            repeat ($urandom_range(1, 6)) queue_beat(REQ_BYTE, 8'($urandom));
          end
        end else begin
          queue_beat(REQ_RESET, 8'($urandom));
        end
      end
      queue_beat(REQ_RESET, 8'($urandom));
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("magic_sync_frame_deframer verification clean");
    end else begin
      $display("magic_sync_frame_deframer verification failed");
    end
    $finish;
  end

endmodule
